### design/sdft_pkg.sv
`timescale 1ns / 1ps

package sdft_pkg;

  // Default sizes of the delay line and the bin bank
  localparam int DEF_MAX_WINDOW = 256;
  localparam int DEF_MAX_BINS   = 64;

  // Fixed field widths
  localparam int BIN_W  = 6;
  localparam int WLEN_W = 9;
  localparam int NBIN_W = 7;

  // Reset values of the configuration registers
  localparam logic [WLEN_W-1:0] WLEN_RST = 9'd256;
  localparam logic [NBIN_W-1:0] NBIN_RST = 7'd64;

  // Command codes carried in tuser
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // Register select (word address bit)
  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_NUM_BINS      = 1'b1;

  typedef struct packed {
    logic signed [15:0] im;
    logic signed [15:0] re;
  } cplx16_t;

  typedef struct packed {
    logic signed [31:0] im;
    logic signed [31:0] re;
  } cplx32_t;

  typedef struct packed {
    logic signed [15:0] tail_im;
    logic signed [15:0] tail_re;
    logic signed [15:0] rot_im;
    logic signed [15:0] rot_re;
  } twid_t;

  // Per-bin control that travels with the arithmetic pipeline
  typedef struct packed {
    logic             valid;
    logic [BIN_W-1:0] bin;
    logic             last;
  } bin_ctl_t;

endpackage

### design/sdft_window.sv
`timescale 1ns / 1ps

module sdft_window #(
  parameter int MAX_WINDOW = sdft_pkg::DEF_MAX_WINDOW
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         restart,
  input  logic                         push,
  input  sdft_pkg::cplx16_t            sample,
  input  logic [sdft_pkg::WLEN_W-1:0]  wlen,
  output sdft_pkg::cplx16_t            oldest,
  output logic                         emit
);
  import sdft_pkg::*;

  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int LEN_W = $clog2(MAX_WINDOW + 1);

  cplx16_t            mem [MAX_WINDOW];
  cplx16_t            rd_r;
  logic               use_r;
  logic               emit_r;
  logic [PTR_W-1:0]   wp_r;
  logic [PTR_W-1:0]   wp_nxt;
  logic [PTR_W-1:0]   ptr;
  logic [LEN_W-1:0]   fill_r;
  logic [LEN_W-1:0]   fill_nxt;
  logic [LEN_W-1:0]   m;
  logic [LEN_W-1:0]   ptr_inc;

  // Effective window length: zero acts as one, clamp at the store depth
  always_comb begin
    if (wlen == '0) begin
      m = LEN_W'(1);
    end else if (32'(wlen) > MAX_WINDOW) begin
      m = LEN_W'(MAX_WINDOW);
    end else begin
      m = LEN_W'(wlen);
    end
  end

  always_comb begin
    ptr      = (LEN_W'(wp_r) >= m) ? '0 : wp_r;
    ptr_inc  = LEN_W'(ptr) + LEN_W'(1);
    wp_nxt   = (ptr_inc >= m) ? '0 : PTR_W'(ptr_inc);
    fill_nxt = (fill_r < m) ? fill_r + LEN_W'(1) : m;
  end

  // Read the oldest sample and overwrite it in the same edge
  always_ff @(posedge clk) begin
    if (push) begin
      rd_r     <= mem[ptr];
      mem[ptr] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      wp_r   <= '0;
      fill_r <= '0;
      use_r  <= 1'b0;
      emit_r <= 1'b0;
    end else if (push) begin
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
      use_r  <= (fill_r >= m);
      emit_r <= (fill_nxt == m);
    end
  end

  assign oldest = use_r ? rd_r : '0;
  assign emit   = emit_r;

endmodule

### design/sdft_bank.sv
`timescale 1ns / 1ps

module sdft_bank #(
  parameter int MAX_BINS = sdft_pkg::DEF_MAX_BINS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        restart,
  input  logic                        tw_we,
  input  logic [sdft_pkg::BIN_W-1:0]  tw_waddr,
  input  sdft_pkg::twid_t             tw_wdata,
  input  logic                        rd_en,
  input  logic [sdft_pkg::BIN_W-1:0]  rd_addr,
  output sdft_pkg::cplx32_t           acc_rd,
  output sdft_pkg::twid_t             tw_rd,
  input  logic                        acc_we,
  input  logic [sdft_pkg::BIN_W-1:0]  acc_waddr,
  input  sdft_pkg::cplx32_t           acc_wdata
);
  import sdft_pkg::*;

  localparam int BIN_AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

  cplx32_t              acc_mem [MAX_BINS];
  twid_t                tw_mem  [MAX_BINS];
  logic [MAX_BINS-1:0]  vld_r;
  cplx32_t              acc_q_r;
  logic                 vld_q_r;
  twid_t                tw_q_r;

  always_ff @(posedge clk) begin
    if (tw_we) begin
      tw_mem[tw_waddr[BIN_AW-1:0]] <= tw_wdata;
    end
    if (rd_en) begin
      tw_q_r <= tw_mem[rd_addr[BIN_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_waddr[BIN_AW-1:0]] <= acc_wdata;
    end
    if (rd_en) begin
      acc_q_r <= acc_mem[rd_addr[BIN_AW-1:0]];
      vld_q_r <= vld_r[rd_addr[BIN_AW-1:0]];
    end
  end

  // An accumulator not written since restart reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      vld_r <= '0;
    end else if (acc_we) begin
      vld_r[acc_waddr[BIN_AW-1:0]] <= 1'b1;
    end
  end

  assign acc_rd = vld_q_r ? acc_q_r : '0;
  assign tw_rd  = tw_q_r;

endmodule

### design/sdft_cmac.sv
`timescale 1ns / 1ps

module sdft_cmac (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  sdft_pkg::bin_ctl_t    ctl_in,
  input  sdft_pkg::cplx32_t     acc,
  input  sdft_pkg::cplx16_t     oldest,
  input  sdft_pkg::cplx16_t     sample,
  input  sdft_pkg::twid_t       tw,
  output sdft_pkg::bin_ctl_t    ctl_out,
  output sdft_pkg::cplx32_t     res,
  output logic                  busy
);
  import sdft_pkg::*;

  bin_ctl_t            s1_ctl_r, s2_ctl_r, s3_ctl_r;
  logic signed [32:0]  dre, dim;
  logic signed [48:0]  p0_r, p1_r, p4_r, p5_r;
  logic signed [31:0]  p2_r, p3_r, p6_r, p7_r;
  logic signed [49:0]  a_re_r, a_im_r;
  logic signed [32:0]  b_re_r, b_im_r;
  logic signed [51:0]  v_re, v_im;
  logic signed [51:0]  t_re, t_im;
  logic signed [36:0]  q_re, q_im;
  cplx32_t             res_r;

  function automatic logic signed [31:0] sat32(input logic signed [36:0] q);
    logic signed [31:0] r;
    if (q[36:31] == {6{q[31]}}) begin
      r = q[31:0];
    end else if (q[36]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  // Subtract the leaving sample from the accumulator
  always_comb begin
    dre = {acc.re[31], acc.re} - {{17{oldest.re[15]}}, oldest.re};
    dim = {acc.im[31], acc.im} - {{17{oldest.im[15]}}, oldest.im};
  end

  // Stage 1: eight partial products
  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= dre * $signed(tw.rot_re);
      p1_r <= dim * $signed(tw.rot_im);
      p2_r <= $signed(sample.re) * $signed(tw.tail_re);
      p3_r <= $signed(sample.im) * $signed(tw.tail_im);
      p4_r <= dre * $signed(tw.rot_im);
      p5_r <= dim * $signed(tw.rot_re);
      p6_r <= $signed(sample.re) * $signed(tw.tail_im);
      p7_r <= $signed(sample.im) * $signed(tw.tail_re);
    end
  end

  // Stage 2: pairwise sums
  always_ff @(posedge clk) begin
    if (en) begin
      a_re_r <= 50'(p0_r) - 50'(p1_r);
      a_im_r <= 50'(p4_r) + 50'(p5_r);
      b_re_r <= 33'(p2_r) - 33'(p3_r);
      b_im_r <= 33'(p6_r) + 33'(p7_r);
    end
  end

  // Stage 3: final add, round half up from Q30, saturate
  always_comb begin
    v_re = 52'(a_re_r) + 52'(b_re_r);
    v_im = 52'(a_im_r) + 52'(b_im_r);
    t_re = v_re + 52'sd16384;
    t_im = v_im + 52'sd16384;
    q_re = t_re[51:15];
    q_im = t_im[51:15];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.re <= sat32(q_re);
      res_r.im <= sat32(q_im);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
    end else if (en) begin
      s1_ctl_r <= ctl_in;
      s2_ctl_r <= s1_ctl_r;
      s3_ctl_r <= s2_ctl_r;
    end
  end

  assign ctl_out = s3_ctl_r;
  assign res     = res_r;
  assign busy    = s1_ctl_r.valid | s2_ctl_r.valid | s3_ctl_r.valid;

endmodule

### design/sliding_dft_bin_bank_unit.sv
`timescale 1ns / 1ps

// Channel  Dir  Payload (low bit up)                                   Handshake
// in_      in   tdata: bin_index, rot_re, rot_im, tail_re, tail_im,    tvalid/tready
//               sample_re, sample_im, 2 pad bits; tuser: command
// out_     out  tdata: value_re, value_im; tuser: out_bin; tlast: last  tvalid/tready
// cfg_     in   APB: 0x0 window_length, 0x4 num_bins                  psel/penable
//
// A twiddle load leaves the block idle for the next transaction. In a sample push,
// one bin a cycle, unless an out_tready stall freezes the whole bin pipeline, goes
// through the shared complex multiply-accumulate, set by its single accumulator read
// port; no new transaction is taken until the sweep drains. Reset (rst_n, synchronous)
// clears the stream state; the twiddle table holds whatever was loaded.

module sliding_dft_bin_bank_unit #(
  parameter int MAX_WINDOW = sdft_pkg::DEF_MAX_WINDOW,
  parameter int MAX_BINS   = sdft_pkg::DEF_MAX_BINS
) (
  input  logic          clk,
  input  logic          rst_n,
  // input transaction stream
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [103:0]  in_tdata,   // bin_index, rot_re, rot_im, tail_re, tail_im,
                                    // sample_re, sample_im, zero pad
  input  logic [0:0]    in_tuser,   // command
  // result stream
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [63:0]   out_tdata,  // value_re, value_im
  output logic [5:0]    out_tuser,  // out_bin
  output logic          out_tlast,
  // configuration
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);
  import sdft_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t               st_r, st_nxt;
  logic [NBIN_W-1:0]    cnt_r, cnt_nxt;
  logic [NBIN_W-1:0]    cnt_inc;
  logic [NBIN_W-1:0]    nb;
  bin_ctl_t             s0_r, s0_nxt;
  logic [WLEN_W-1:0]    wlen_r;
  logic [NBIN_W-1:0]    nbin_r;
  cplx16_t              smp_r;
  cplx16_t              in_smp;
  twid_t                in_tw;
  logic                 in_acc, push_acc, load_acc;
  logic                 cfg_we, restart;
  logic                 adv, issue;
  cplx16_t              oldest;
  logic                 emit;
  cplx32_t              acc_rd;
  twid_t                tw_rd;
  bin_ctl_t             res_ctl;
  cplx32_t              res;
  logic                 busy;
  logic                 out_valid_r;
  cplx32_t              out_val_r;
  logic [BIN_W-1:0]     out_bin_r;
  logic                 out_last_r;

  // Unpack the input transaction
  assign in_tw.rot_re  = in_tdata[21:6];
  assign in_tw.rot_im  = in_tdata[37:22];
  assign in_tw.tail_re = in_tdata[53:38];
  assign in_tw.tail_im = in_tdata[69:54];
  assign in_smp.re     = in_tdata[85:70];
  assign in_smp.im     = in_tdata[101:86];

  assign in_tready = (st_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign push_acc  = in_acc && (in_tuser[0] == CMD_PUSH);
  // drop loads aimed past the bin bank
  assign load_acc  = in_acc && (in_tuser[0] == CMD_LOAD) &&
                     (32'(in_tdata[5:0]) < MAX_BINS);

  // Configuration: any write restarts the stream
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign restart    = cfg_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= WLEN_RST;
      nbin_r <= NBIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_paddr[2])
        REG_WINDOW_LENGTH: wlen_r <= cfg_pwdata[WLEN_W-1:0];
        REG_NUM_BINS:      nbin_r <= cfg_pwdata[NBIN_W-1:0];
        default:           wlen_r <= wlen_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_WINDOW_LENGTH: cfg_prdata = 32'(wlen_r);
      REG_NUM_BINS:      cfg_prdata = 32'(nbin_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // Effective bin count: zero acts as one, clamp at the bank size
  always_comb begin
    if (nbin_r == '0) begin
      nb = NBIN_W'(1);
    end else if (32'(nbin_r) > MAX_BINS) begin
      nb = NBIN_W'(MAX_BINS);
    end else begin
      nb = nbin_r;
    end
  end

  // Hold the whole pipeline while a result waits at the output
  assign adv   = !out_valid_r || out_tready;
  assign issue = adv && (st_r == ST_RUN);
  assign cnt_inc = cnt_r + NBIN_W'(1);

  // Sequencer: issue one bin a cycle while the output does not stall, then drain the pipeline
  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    s0_nxt  = s0_r;
    if (adv) begin
      s0_nxt.valid = 1'b0;
    end
    unique case (st_r)
      ST_IDLE: begin
        if (push_acc) begin
          st_nxt  = ST_RUN;
          cnt_nxt = '0;
        end
      end
      ST_RUN: begin
        if (adv) begin
          s0_nxt.valid = 1'b1;
          s0_nxt.bin   = cnt_r[BIN_W-1:0];
          s0_nxt.last  = (cnt_inc == nb);
          cnt_nxt      = cnt_inc;
          if (cnt_inc == nb) begin
            st_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!s0_r.valid && !busy) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      cnt_r <= '0;
      s0_r  <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      s0_r  <= s0_nxt;
    end
  end

  // Latch the sample for the whole bin sweep
  always_ff @(posedge clk) begin
    if (push_acc) begin
      smp_r <= in_smp;
    end
  end

  sdft_window #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (restart),
    .push    (push_acc),
    .sample  (in_smp),
    .wlen    (wlen_r),
    .oldest  (oldest),
    .emit    (emit)
  );

  sdft_bank #(
    .MAX_BINS (MAX_BINS)
  ) u_bank (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (restart),
    .tw_we     (load_acc),
    .tw_waddr  (in_tdata[5:0]),
    .tw_wdata  (in_tw),
    .rd_en     (issue),
    .rd_addr   (cnt_r[BIN_W-1:0]),
    .acc_rd    (acc_rd),
    .tw_rd     (tw_rd),
    .acc_we    (adv && res_ctl.valid),
    .acc_waddr (res_ctl.bin),
    .acc_wdata (res)
  );

  sdft_cmac u_cmac (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .ctl_in  (s0_r),
    .acc     (acc_rd),
    .oldest  (oldest),
    .sample  (smp_r),
    .tw      (tw_rd),
    .ctl_out (res_ctl),
    .res     (res),
    .busy    (busy)
  );

  // Output register: present a result only once the window is full
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_ctl.valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_val_r  <= res;
      out_bin_r  <= res_ctl.bin;
      out_last_r <= res_ctl.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_val_r.im, out_val_r.re};
  assign out_tuser  = out_bin_r;
  assign out_tlast  = out_last_r;

endmodule

### bench/tb_sliding_dft_bin_bank_unit.sv
`timescale 1ns / 1ps

module tb_sliding_dft_bin_bank_unit;
  import sdft_pkg::*;

  localparam int WINDOW_CAP    = DEF_MAX_WINDOW;
  localparam int BIN_CAP       = DEF_MAX_BINS;
  localparam int IDLE_LIMIT    = 3000;  // cycles without any transaction before giving up
  localparam int SETTLE_CYCLES = 120;   // lets a trailing push finish its bin sweep
  localparam int LONG_HOLD     = 400;   // long output back-pressure stretch
  localparam int MAX_REPORTS   = 100;

  // One input transaction: a sample push or a twiddle load for one bin
  typedef struct packed {
    logic             cmd;
    logic [BIN_W-1:0] bin;
    twid_t            tw;
    cplx16_t          smp;
  } sdft_item_t;

  // One windowed DFT value as the result channel carries it
  typedef struct packed {
    logic [BIN_W-1:0]   bin;
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               last;
  } bin_value_t;

  // Output-ready patterns of the receiver
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [103:0]  in_tdata = '0;   // bin_index, rot_re, rot_im, tail_re, tail_im,
                                  // sample_re, sample_im, zero pad
  logic [0:0]    in_tuser = '0;   // command
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [63:0]   out_tdata;       // value_re, value_im
  logic [5:0]    out_tuser;       // out_bin
  logic          out_tlast;
  logic          cfg_psel = 1'b0;
  logic          cfg_penable = 1'b0;
  logic          cfg_pwrite = 1'b0;
  logic [2:0]    cfg_paddr = '0;
  logic [31:0]   cfg_pwdata = '0;
  logic [31:0]   cfg_prdata;
  logic          cfg_pready;

  always #4 clk = ~clk;

  sliding_dft_bin_bank_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Stimulus waiting for the sender, and DFT values waiting for the result channel
  sdft_item_t pending_items[$];
  bin_value_t bin_value_q[$];

  // Predictor copy of the block state
  cplx16_t           delay_line [WINDOW_CAP] = '{default: '0};
  cplx32_t           acc_bank   [BIN_CAP]    = '{default: '0};
  twid_t             twid_tab   [BIN_CAP]    = '{default: '0};
  logic [WLEN_W-1:0] wlen_reg = WLEN_RST;
  logic [NBIN_W-1:0] nbin_reg = NBIN_RST;
  int unsigned       fill_cnt = 0;
  int unsigned       wr_ptr = 0;

  int         err_cnt = 0;
  int         idle_cycles = 0;
  bit         long_hold_req = 1'b0;
  sdft_item_t cur_item;
  int         gap_left = 0;
  int         burst_left = 0;
  int         hold_left = 0;
  int         mode_left = 0;
  rx_mode_t   rx_mode = RX_OPEN;
  logic [2:0] cadence = '0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Q30 -> Q15 with round half up (floor shift), then clamp to 32 bits
  function automatic logic signed [31:0] round_q30(longint v);
    longint q;
    q = (v + 64'sd16384) >>> 15;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    else if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  // Any register write restarts the stream; the twiddle table survives
  task automatic restart_stream();
    fill_cnt = 0;
    wr_ptr   = 0;
    foreach (acc_bank[b]) acc_bank[b] = '0;
  endtask

  // Advance the delay line and every active bin by one sample, queue the values once the window is full
  task automatic bank_push(cplx16_t smp);
    int unsigned m, nb, ptr;
    cplx16_t     oldest;
    longint      dre, dim, rr, ri, tr, ti, sr, si;
    bin_value_t  v;
    m  = (wlen_reg == 0) ? 1 : (wlen_reg > WINDOW_CAP) ? WINDOW_CAP : wlen_reg;
    nb = (nbin_reg == 0) ? 1 : (nbin_reg > BIN_CAP) ? BIN_CAP : nbin_reg;
    ptr = (wr_ptr >= m) ? 0 : wr_ptr;
    // while the window fills, the sample leaving it counts as zero
    oldest = '0;
    if (fill_cnt >= m) oldest = delay_line[ptr];
    delay_line[ptr] = smp;
    wr_ptr = (ptr + 1 >= m) ? 0 : ptr + 1;
    if (fill_cnt < m) fill_cnt++;
    sr = smp.re;
    si = smp.im;
    for (int b = 0; b < nb; b++) begin
      rr  = twid_tab[b].rot_re;
      ri  = twid_tab[b].rot_im;
      tr  = twid_tab[b].tail_re;
      ti  = twid_tab[b].tail_im;
      dre = longint'(acc_bank[b].re) - longint'(oldest.re);
      dim = longint'(acc_bank[b].im) - longint'(oldest.im);
      acc_bank[b].re = round_q30(dre * rr - dim * ri + sr * tr - si * ti);
      acc_bank[b].im = round_q30(dre * ri + dim * rr + sr * ti + si * tr);
    end
    // results only once the window is full
    if (fill_cnt >= m) begin
      for (int b = 0; b < nb; b++) begin
        v.bin  = b[BIN_W-1:0];
        v.re   = acc_bank[b].re;
        v.im   = acc_bank[b].im;
        v.last = (b + 1 == nb);
        bin_value_q.push_back(v);
      end
    end
  endtask

  task automatic bank_accept(sdft_item_t it);
    if (it.cmd == CMD_LOAD) twid_tab[it.bin] = it.tw;
    else bank_push(it.smp);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Tame values keep |z| <= 1 so accumulators stay mostly in range
  function automatic logic signed [15:0] rand_q15(bit tame);
    if (tame) return 16'($urandom_range(0, 46340)) - 16'd23170;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic twid_t rand_twid();
    twid_t t;
    bit    tame;
    tame = ($urandom_range(0, 4) != 0);
    t.rot_re  = rand_q15(tame);
    t.rot_im  = rand_q15(tame);
    t.tail_re = rand_q15(tame);
    t.tail_im = rand_q15(tame);
    return t;
  endfunction

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic sdft_item_t rand_item(int load_pct);
    sdft_item_t it;
    it.cmd    = ($urandom_range(0, 99) < load_pct) ? CMD_LOAD : CMD_PUSH;
    it.bin    = BIN_W'($urandom_range(0, BIN_CAP - 1));
    it.tw     = rand_twid();
    it.smp.re = rand_sample();
    it.smp.im = rand_sample();
    return it;
  endfunction

  task automatic queue_sample(logic signed [15:0] re, logic signed [15:0] im);
    sdft_item_t it;
    it        = rand_item(0);
    it.smp.re = re;
    it.smp.im = im;
    pending_items.push_back(it);
  endtask

  task automatic queue_load(int bin, logic signed [15:0] rr, logic signed [15:0] ri,
                            logic signed [15:0] tr, logic signed [15:0] ti);
    sdft_item_t it;
    it            = rand_item(0);
    it.cmd        = CMD_LOAD;
    it.bin        = BIN_W'(bin);
    it.tw.rot_re  = rr;
    it.tw.rot_im  = ri;
    it.tw.tail_re = tr;
    it.tw.tail_im = ti;
    pending_items.push_back(it);
  endtask

  // APB write: setup cycle, access cycle, register lands when pready is seen
  task automatic cfg_write(logic reg_sel, int unsigned val);
    logic [31:0] word;
    // junk in the unused upper bits must be ignored
    word = (reg_sel == REG_WINDOW_LENGTH) ? ($urandom() << 9) | (val & 32'h1ff)
                                          : ($urandom() << 7) | (val & 32'h7f);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_sel, 2'b00};
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (reg_sel == REG_WINDOW_LENGTH) wlen_reg = word[WLEN_W-1:0];
    else nbin_reg = word[NBIN_W-1:0];
    restart_stream();
  endtask

  // Hold until everything is sent and answered, then let a trailing push finish
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_tvalid || bin_value_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(int unsigned wlen, int unsigned nbins, int count, int load_pct,
                           bit squeeze);
    cfg_write(REG_WINDOW_LENGTH, wlen);
    cfg_write(REG_NUM_BINS, nbins);
    repeat (count) pending_items.push_back(rand_item(load_pct));
    // stall the result side long enough for the block to back up its input
    if (squeeze) begin
      repeat (40) @(negedge clk);
      long_hold_req = 1'b1;
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps, hold each item until taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      // the offered transaction (if any) was taken at this edge
      if (in_tvalid) bank_accept(cur_item);
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        cur_item = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {2'b00, cur_item.smp, cur_item.tw, cur_item.bin};
        in_tuser  <= cur_item.cmd;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: its own ready pattern, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cadence <= cadence + 3'd1;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left     = LONG_HOLD;
      out_tready   <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 80);
      end
      mode_left--;
      case (rx_mode)
        RX_OPEN:   out_tready <= 1'b1;
        RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
        default:   out_tready <= (cadence < 3'd3);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every result against the oldest predicted value
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    bin_value_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (bin_value_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $error("out_bin mismatch: expected no result, got bin %0d", out_tuser);
      end else begin
        want = bin_value_q.pop_front();
        check_field("out_bin", want.bin, out_tuser);
        check_field("value_re", want.re, $signed(out_tdata[31:0]));
        check_field("value_im", want.im, $signed(out_tdata[63:32]));
        check_field("last", want.last, out_tlast);
      end
    end
  end

  // Watchdog: give up after a long stretch without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pready)) begin
        idle_cycles = 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_sliding_dft_bin_bank_unit NOT OK");
        $finish;
      end else begin
        idle_cycles++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Load every bin before any push can touch it. Bin 0 grows by sqrt(2) per
    // sample so it runs into saturation; bin 1 uses the opposite corners.
    queue_load(0, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
    queue_load(1, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh0000);
    for (int b = 2; b < BIN_CAP; b++) pending_items.push_back(rand_item(100));
    for (int b = 2; b < BIN_CAP; b++) pending_items[b].bin = BIN_W'(b);
    // default window of 256 is still filling: these pushes give no result
    repeat (2) queue_sample(rand_sample(), rand_sample());
    wait_idle();

    // One-sample window, one bin: sample extremes, and reloads between pushes
    cfg_write(REG_WINDOW_LENGTH, 1);
    cfg_write(REG_NUM_BINS, 1);
    queue_sample(16'sh7fff, 16'sh7fff);
    queue_sample(16'sh8000, 16'sh8000);
    queue_sample(16'sh0000, 16'sh0000);
    queue_sample(16'sh7fff, 16'sh8000);
    queue_sample(16'shffff, 16'sh0001);
    queue_sample(16'sh8000, 16'sh7fff);
    queue_load(0, 16'sh7fff, 16'sh0000, 16'sh7fff, 16'sh0000);
    queue_sample(16'sh7fff, 16'sh7fff);
    queue_sample(16'sh8000, 16'sh0000);
    queue_load(0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    repeat (6) queue_sample(16'sh8000, 16'sh7fff);
    queue_sample(16'sh0001, 16'shffff);
    wait_idle();

    // Register values beyond the range: 0 acts as 1, 127 as all 64 bins
    run_phase(0, 127, 10, 0, 1'b0);
    run_phase(5, 6, 12, 20, 1'b0);
    // 511 acts as the full 256-sample window, which stays filling here
    run_phase(511, 0, 6, 3, 1'b0);
    // all 64 bins with a long output stall in the middle
    run_phase(3, 64, 12, 15, 1'b1);
    repeat (2) run_phase($urandom_range(2, 12), $urandom_range(1, 64), 5, 15, 1'b0);

    if (err_cnt == 0 && bin_value_q.size() == 0) begin
      $display("tb_sliding_dft_bin_bank_unit OK");
    end else begin
      $display("tb_sliding_dft_bin_bank_unit NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
design/sdft_pkg.sv
design/sdft_window.sv
design/sdft_bank.sv
design/sdft_cmac.sv
design/sliding_dft_bin_bank_unit.sv
bench/tb_sliding_dft_bin_bank_unit.sv
